FILE: src/assert_macros.svh
// Assertion macros shared by the matrix element RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/scme_pkg.sv
// Shared types and constants for the Slater-Condon matrix element unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
package scme_pkg;

   localparam int IDX_W = 4;
   localparam int ACC_W = 48;
   localparam int OUT_W = 40;
   localparam int CNT_W = 5;

   localparam logic [1:0] MODE_H_WRITE = 2'd0;
   localparam logic [1:0] MODE_J_WRITE = 2'd1;
   localparam logic [1:0] MODE_COMPUTE = 2'd2;

   localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] OUT_LO = -OUT_HI - ACC_W'(1);

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ALIGN_I,
      OP_ALIGN_J,
      OP_ALIGN_WB,
      OP_UNIQ_B,
      OP_UNIQ_A,
      OP_DIAG_H,
      OP_DIAG_I,
      OP_DIAG_J,
      OP_SING_H,
      OP_SING_J,
      OP_DOUB,
      OP_SUM,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic i_eq;
      logic i_last;
      logic j_last;
      logic uniq_zero;
      logic uniq_two;
      logic uniq_four;
      logic out_busy;
   } status_type;

   function automatic logic signed [OUT_W-1:0] saturate(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] y;
      begin
         y = x;
         if (x > OUT_HI) begin
            y = OUT_HI;
         end else if (x < OUT_LO) begin
            y = OUT_LO;
         end
         return y[OUT_W-1:0];
      end
   endfunction

endpackage

FILE: src/slater_condon_matrix_element.sv
// Slater-Condon matrix element unit: top level joining the sequencer and datapath.
// Depends on scme_pkg, scme_ctrl and scme_datapath.
`timescale 1ns / 1ps
// A table-write transaction (mode 0 for the one-electron table, mode 1 for the
// two-electron table) gives no result. A compute transaction carries two
// determinants and returns one result; it runs a load step, the alignment loop,
// the unique list, a dispatch step, the evaluation (longest for the diagonal case)
// and the drain, sum and emit steps; the emit step also waits while the previous
// result still waits on rsp_stall.
// The serial alignment loop and the single read port of the two-electron memory
// set its length. The next transaction is taken while a result waits on rsp_stall.
// Both tables hold whatever was last written; an entry never written reads as
// an arbitrary value.
module slater_condon_matrix_element import scme_pkg::*; #(
   parameter int ELECTRONS  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_mode,
   input  logic [15:0]                req_table_address,
   input  logic signed [31:0]         req_table_value,
   input  logic [IDX_W*ELECTRONS-1:0] req_det_a,
   input  logic [IDX_W*ELECTRONS-1:0] req_det_b,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_W-1:0]    rsp_matrix_element,
   output logic [CNT_W-1:0]           rsp_difference_count
);

   cmd_type    cmd;
   status_type status;

   scme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   scme_datapath #(
      .ELECTRONS  (ELECTRONS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_table_address    (req_table_address),
      .req_table_value      (req_table_value),
      .req_det_a            (req_det_a),
      .req_det_b            (req_det_b),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_matrix_element   (rsp_matrix_element),
      .rsp_difference_count (rsp_difference_count),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

FILE: src/scme_datapath.sv
// Datapath of the matrix element unit: determinant registers, integral memories,
// accumulators and the result register. Depends on scme_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scme_datapath import scme_pkg::*; #(
   parameter int ELECTRONS  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_mode,
   input  logic [15:0]               req_table_address,
   input  logic signed [31:0]        req_table_value,
   input  logic [IDX_W*ELECTRONS-1:0] req_det_a,
   input  logic [IDX_W*ELECTRONS-1:0] req_det_b,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic signed [OUT_W-1:0]   rsp_matrix_element,
   output logic [CNT_W-1:0]          rsp_difference_count,
   input  cmd_type                   cmd,
   output status_type                status
);

   localparam int MEM_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int IW    = (ELECTRONS > 1) ? $clog2(ELECTRONS) : 1;
   localparam int NW    = ($clog2(2 * ELECTRONS + 1) > CNT_W) ? $clog2(2 * ELECTRONS + 1) : CNT_W;
   localparam logic [IW-1:0] LAST = IW'(ELECTRONS - 1);

   logic signed [MEM_W-1:0] h_mem [256];
   logic signed [MEM_W-1:0] j_mem [65536];
   logic signed [MEM_W-1:0] h_q_ff;
   logic signed [MEM_W-1:0] j_q_ff;
   logic                    h_rd_ff;
   logic                    j_rd_ff;
   logic                    h_re;
   logic                    j_re;
   logic [7:0]              h_ra;
   logic [15:0]             j_ra;
   logic                    accept;

   logic [IDX_W-1:0] a_ff [ELECTRONS];
   logic [IDX_W-1:0] b_ff [ELECTRONS];
   logic [15:0]      pa_ff;
   logic [15:0]      pb_ff;
   logic [15:0]      mask_a;
   logic [15:0]      mask_b;
   logic [IDX_W-1:0] cur_ff;
   logic [IDX_W-1:0] ai_ff;
   logic [IDX_W-1:0] u_ff [4];
   logic [IW-1:0]    i_ff;
   logic [IW-1:0]    j_ff;
   logic [IW-1:0]    i_in;
   logic [IW-1:0]    j_in;
   logic             swap_ff;
   logic [NW-1:0]    nuni_ff;

   logic signed [ACC_W-1:0] acc_h_ff;
   logic signed [ACC_W-1:0] acc_j_ff;
   logic signed [ACC_W-1:0] sum_ff;
   logic signed [OUT_W-1:0] clamp_pos;
   logic signed [OUT_W-1:0] clamp_neg;

   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_elem_ff;
   logic [CNT_W-1:0]        rsp_count_ff;

   logic [IDX_W-1:0] a_i;
   logic [IDX_W-1:0] b_i;
   logic [IDX_W-1:0] a_j;
   logic [IDX_W-1:0] b_j;

   assign accept = req_valid && !req_stall;

   assign a_i = a_ff[i_ff];
   assign b_i = b_ff[i_ff];
   assign a_j = a_ff[j_ff];
   assign b_j = b_ff[j_ff];

   assign i_in = (i_ff == LAST) ? '0 : i_ff + IW'(1);
   assign j_in = (j_ff == LAST) ? '0 : j_ff + IW'(1);

   always_comb begin
      mask_a = '0;
      mask_b = '0;
      for (int k = 0; k < ELECTRONS; k++) begin
         mask_a[req_det_a[IDX_W*k +: IDX_W]] = 1'b1;
         mask_b[req_det_b[IDX_W*k +: IDX_W]] = 1'b1;
      end
   end

   always_comb begin
      h_re = 1'b0;
      j_re = 1'b0;
      h_ra = '0;
      j_ra = '0;
      case (cmd.op)
         OP_DIAG_H: begin
            h_re = 1'b1;
            h_ra = {a_i, a_i};
         end
         OP_SING_H: begin
            h_re = 1'b1;
            h_ra = {u_ff[0], u_ff[1]};
         end
         OP_DIAG_J: begin
            j_re = 1'b1;
            j_ra = {ai_ff, a_j, ai_ff, a_j};
         end
         OP_SING_J: begin
            j_re = (a_i == b_i);
            j_ra = {u_ff[0], a_i, u_ff[1], a_i};
         end
         OP_DOUB: begin
            j_re = 1'b1;
            j_ra = {u_ff[0], u_ff[1], u_ff[2], u_ff[3]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_H_WRITE) begin
         h_mem[req_table_address[7:0]] <= req_table_value[MEM_W-1:0];
      end
      h_q_ff <= h_mem[h_ra];
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_J_WRITE) begin
         j_mem[req_table_address] <= req_table_value[MEM_W-1:0];
      end
      j_q_ff <= j_mem[j_ra];
   end

   assign clamp_pos = saturate(sum_ff);
   assign clamp_neg = saturate(-ACC_W'(clamp_pos));

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         nuni_ff      <= '0;
         h_rd_ff      <= 1'b0;
         j_rd_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         h_rd_ff <= h_re;
         j_rd_ff <= j_re;
         if (h_rd_ff) begin
            acc_h_ff <= acc_h_ff + ACC_W'(h_q_ff);
         end
         if (j_rd_ff) begin
            acc_j_ff <= acc_j_ff + ACC_W'(j_q_ff);
         end
         if (rsp_valid_ff && !rsp_stall && cmd.op != OP_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_LOAD: begin
               for (int k = 0; k < ELECTRONS; k++) begin
                  a_ff[k] <= req_det_a[IDX_W*k +: IDX_W];
                  b_ff[k] <= req_det_b[IDX_W*k +: IDX_W];
               end
               pa_ff    <= mask_a;
               pb_ff    <= mask_b;
               i_ff     <= '0;
               j_ff     <= '0;
               swap_ff  <= 1'b0;
               nuni_ff  <= '0;
               acc_h_ff <= '0;
               acc_j_ff <= '0;
            end
            OP_ALIGN_I: begin
               if (a_i == b_i) begin
                  i_ff <= i_in;
               end else begin
                  cur_ff <= a_i;
                  j_ff   <= '0;
               end
            end
            OP_ALIGN_J: begin
               if (cur_ff == b_j) begin
                  swap_ff <= ~swap_ff;
                  if (j_ff != i_ff) begin
                     cur_ff     <= a_j;
                     a_ff[j_ff] <= cur_ff;
                  end
               end
               j_ff <= j_in;
            end
            OP_ALIGN_WB: begin
               a_ff[i_ff] <= cur_ff;
               i_ff       <= i_in;
            end
            OP_UNIQ_B: begin
               if (!pa_ff[b_i]) begin
                  if (nuni_ff < NW'(4)) begin
                     u_ff[nuni_ff[1:0]] <= b_i;
                  end
                  nuni_ff <= nuni_ff + NW'(1);
               end
               i_ff <= i_in;
            end
            OP_UNIQ_A: begin
               if (!pb_ff[a_i]) begin
                  if (nuni_ff < NW'(4)) begin
                     u_ff[nuni_ff[1:0]] <= a_i;
                  end
                  nuni_ff <= nuni_ff + NW'(1);
               end
               i_ff <= i_in;
            end
            OP_DIAG_H: begin
               i_ff <= i_in;
            end
            OP_DIAG_I: begin
               ai_ff <= a_i;
               j_ff  <= '0;
            end
            OP_DIAG_J: begin
               j_ff <= j_in;
               if (j_ff == LAST) begin
                  i_ff <= i_in;
               end
            end
            OP_SING_J: begin
               i_ff <= i_in;
            end
            OP_SUM: begin
               sum_ff <= acc_h_ff + ((nuni_ff == '0) ? (acc_j_ff >>> 1) : acc_j_ff);
            end
            OP_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_elem_ff  <= swap_ff ? clamp_neg : clamp_pos;
               rsp_count_ff <= (nuni_ff > NW'(31)) ? CNT_W'(31) : nuni_ff[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign status.i_eq      = (a_i == b_i);
   assign status.i_last    = (i_ff == LAST);
   assign status.j_last    = (j_ff == LAST);
   assign status.uniq_zero = (nuni_ff == NW'(0));
   assign status.uniq_two  = (nuni_ff == NW'(2));
   assign status.uniq_four = (nuni_ff == NW'(4));
   assign status.out_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matrix_element   = rsp_elem_ff;
   assign rsp_difference_count = rsp_count_ff;

   `ASSERT_NEXT(emit_sets_valid, cmd.op == OP_EMIT, rsp_valid_ff)
   `ASSERT_IMPLIES(uniq_bounded, 1'b1, nuni_ff <= NW'(2 * ELECTRONS))

endmodule

FILE: src/scme_ctrl.sv
// Sequencer of the matrix element unit: steps alignment, unique list and evaluation.
// Drives datapath commands and the input stall. Depends on scme_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scme_ctrl import scme_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AL_I,
      ST_AL_J,
      ST_AL_WB,
      ST_UNIQ_B,
      ST_UNIQ_A,
      ST_DISPATCH,
      ST_DIAG_H,
      ST_DIAG_I,
      ST_DIAG_J,
      ST_SING_H,
      ST_SING_J,
      ST_DOUB,
      ST_DRAIN,
      ST_SUM,
      ST_EMIT
   } state_type;

   state_type state_ff;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE:     cmd.op = (req_valid && req_mode == MODE_COMPUTE) ? OP_LOAD : OP_NONE;
         ST_AL_I:     cmd.op = OP_ALIGN_I;
         ST_AL_J:     cmd.op = OP_ALIGN_J;
         ST_AL_WB:    cmd.op = OP_ALIGN_WB;
         ST_UNIQ_B:   cmd.op = OP_UNIQ_B;
         ST_UNIQ_A:   cmd.op = OP_UNIQ_A;
         ST_DISPATCH: cmd.op = OP_NONE;
         ST_DIAG_H:   cmd.op = OP_DIAG_H;
         ST_DIAG_I:   cmd.op = OP_DIAG_I;
         ST_DIAG_J:   cmd.op = OP_DIAG_J;
         ST_SING_H:   cmd.op = OP_SING_H;
         ST_SING_J:   cmd.op = OP_SING_J;
         ST_DOUB:     cmd.op = OP_DOUB;
         ST_DRAIN:    cmd.op = OP_NONE;
         ST_SUM:      cmd.op = OP_SUM;
         ST_EMIT:     cmd.op = status.out_busy ? OP_NONE : OP_EMIT;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_mode == MODE_COMPUTE) begin
                  state_ff <= ST_AL_I;
               end
            end
            ST_AL_I: begin
               if (!status.i_eq) begin
                  state_ff <= ST_AL_J;
               end else if (status.i_last) begin
                  state_ff <= ST_UNIQ_B;
               end
            end
            ST_AL_J: begin
               if (status.j_last) begin
                  state_ff <= ST_AL_WB;
               end
            end
            ST_AL_WB: begin
               state_ff <= status.i_last ? ST_UNIQ_B : ST_AL_I;
            end
            ST_UNIQ_B: begin
               if (status.i_last) begin
                  state_ff <= ST_UNIQ_A;
               end
            end
            ST_UNIQ_A: begin
               if (status.i_last) begin
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               if (status.uniq_zero) begin
                  state_ff <= ST_DIAG_H;
               end else if (status.uniq_two) begin
                  state_ff <= ST_SING_H;
               end else if (status.uniq_four) begin
                  state_ff <= ST_DOUB;
               end else begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DIAG_H: begin
               if (status.i_last) begin
                  state_ff <= ST_DIAG_I;
               end
            end
            ST_DIAG_I: begin
               state_ff <= ST_DIAG_J;
            end
            ST_DIAG_J: begin
               if (status.j_last) begin
                  state_ff <= status.i_last ? ST_DRAIN : ST_DIAG_I;
               end
            end
            ST_SING_H: begin
               state_ff <= ST_SING_J;
            end
            ST_SING_J: begin
               if (status.i_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DOUB: begin
               state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!status.out_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_NEXT(drain_then_sum, state_ff == ST_DRAIN, state_ff == ST_SUM)

endmodule
